FILE: rtl/core/mavrp_pkg.sv
// Shared types and constants for the MPEG audio/video RTP packetizer.
// Holds the item structs, command codes and payload size limits.
// No dependencies.
package mavrp_pkg;

    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [12:0] PAY_MIN   = 13'd512;
    localparam logic [12:0] PAY_MAX   = 13'd4096;
    localparam logic [12:0] PAY_RESET = 13'd1400;
    localparam logic [2:0]  HDR_BYTES = 3'd4;

    localparam logic [1:0] CMD_AUDIO = 2'd0;
    localparam logic [1:0] CMD_VIDEO = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] frame_id;
        logic [13:0] frame_len;
        logic [31:0] frame_stamp;
    } t_in_item;

    typedef struct packed {
        logic        is_video;
        logic [15:0] chunk_frame;
        logic [13:0] chunk_start;
        logic [12:0] chunk_bytes;
        logic        has_audio_header;
        logic [15:0] header_offset;
        logic [31:0] packet_stamp;
        logic        marker;
        logic        end_of_packet;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] id;
        logic [13:0] len;
    } t_qentry;

endpackage

FILE: rtl/core/mpeg_audio_video_rtp_packetizer_unit.sv
// Top level of the MPEG audio/video RTP packetizer: frame descriptors in,
// payload chunk descriptors out. Depends on mavrp_pkg.

// The block takes one item at a time: an audio frame, a video frame or a
// flush command, and answers with zero or more chunk descriptors, one per
// output item, with last set on the final one. Small audio frames are held
// in an on-chip queue of QUEUE_DEPTH entries (a synchronous memory with a
// registered read) and sent together as one packet when the next frame would
// overflow the payload, when the queue fills or on a flush command. Large
// audio frames and all video frames are cut into pieces of the payload size
// (less the 4-byte audio header for audio). An item is first accepted and
// decoded, then each queued entry that is sent takes a memory read and an
// output load, then the frame is written to the queue, or its fragments or
// video pieces go out one by one. The longest work for one item is a flush
// of the seven frames that the queue can hold between items, followed by
// the 33 fragments of the longest audio frame at the smallest payload size.
// A frame that fills the queue is written and then the whole queue is sent.
// The sequencer walks the queue memory and the fragment loop, and output
// backpressure stalls it. A finished chunk waits in the output register
// while the sequencer keeps working.
// The payload size register is saturated to 512..4096 when written and may
// be changed only while the block is idle. There is no clearing pass after
// reset: the queue is tracked by its fill count.
module mpeg_audio_video_rtp_packetizer_unit
    import mavrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FL_RD,
        ST_FL_OUT,
        ST_QWRITE,
        ST_SPLIT
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_item, n_item;
    logic [12:0]        r_pay;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [12:0]        r_bytes, n_bytes;
    logic [31:0]        r_first, n_first;
    logic [QA_W-1:0]    r_idx, n_idx;
    logic [13:0]        r_off, n_off;
    logic               r_vid, n_vid;
    logic               r_fits, n_fits;
    logic               r_more, n_more;
    logic               r_post, n_post;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data;

    // Queue memory: one write port, one registered read port.
    t_qentry            mem_q [QUEUE_DEPTH];
    t_qentry            r_rd_data;
    logic               mem_we, mem_re;
    t_qentry            mem_wd;

    logic               out_free, out_load;
    t_out_item          out_d;

    // Decode terms used while deciding on an item.
    logic [14:0]        need;
    logic [15:0]        sum_bytes;
    logic               is_audio, is_flush, over, fits, pre, post;
    logic [CNT_W-1:0]   cnt_after;
    // Fragment loop terms.
    logic [12:0]        space, piece;
    logic [13:0]        pend;
    logic               fin;
    logic               q_last;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign need      = {1'b0, r_item.frame_len} + {12'd0, HDR_BYTES};
    assign sum_bytes = {3'd0, r_bytes} + {1'b0, need};
    assign is_audio  = (r_item.cmd == CMD_AUDIO);
    assign is_flush  = (r_item.cmd == CMD_FLUSH);
    assign over      = sum_bytes > {3'd0, r_pay};
    assign fits      = need < {2'd0, r_pay};
    assign pre       = (is_audio && (r_count != '0) &&
                        (over || (fits && (r_count >= CNT_W'(QUEUE_DEPTH))))) ||
                       (is_flush && (r_count != '0));
    assign cnt_after = pre ? '0 : r_count;
    assign post      = is_audio && fits && ((cnt_after + 1'b1) == CNT_W'(QUEUE_DEPTH));

    assign space = r_vid ? r_pay : (r_pay - {10'd0, HDR_BYTES});
    assign pend  = r_item.frame_len - r_off;
    assign fin   = pend <= {1'b0, space};
    assign piece = fin ? pend[12:0] : space;

    assign q_last = (CNT_W'(r_idx) + 1'b1) == r_count;

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_count  = r_count;
        n_bytes  = r_bytes;
        n_first  = r_first;
        n_idx    = r_idx;
        n_off    = r_off;
        n_vid    = r_vid;
        n_fits   = r_fits;
        n_more   = r_more;
        n_post   = r_post;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_wd   = '{id: r_item.frame_id, len: r_item.frame_len};
        out_load = 1'b0;
        out_d    = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_fits = fits;
                n_more = (is_audio && !fits) || post;
                n_post = 1'b0;
                n_idx  = '0;
                n_off  = '0;
                n_vid  = (r_item.cmd == CMD_VIDEO);
                if (pre) begin
                    n_state = ST_FL_RD;
                end else if (is_audio && fits) begin
                    n_state = ST_QWRITE;
                end else if (is_audio) begin
                    n_state = ST_SPLIT;
                end else if ((r_item.cmd == CMD_VIDEO) && (r_item.frame_len != '0)) begin
                    n_state = ST_SPLIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FL_RD: begin
                mem_re  = 1'b1;
                n_state = ST_FL_OUT;
            end
            ST_FL_OUT: begin
                if (out_free) begin
                    out_load               = 1'b1;
                    out_d.is_video         = 1'b0;
                    out_d.chunk_frame      = r_rd_data.id;
                    out_d.chunk_start      = '0;
                    out_d.chunk_bytes      = r_rd_data.len[12:0];
                    out_d.has_audio_header = 1'b1;
                    out_d.header_offset    = '0;
                    out_d.packet_stamp     = r_first;
                    out_d.marker           = 1'b1;
                    out_d.end_of_packet    = q_last;
                    out_d.last             = q_last && !r_more;
                    if (q_last) begin
                        n_count = '0;
                        n_bytes = '0;
                        if (r_post) begin
                            n_state = ST_IDLE;
                        end else if (is_audio && r_fits) begin
                            n_state = ST_QWRITE;
                        end else if (is_audio) begin
                            n_state = ST_SPLIT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_FL_RD;
                    end
                end
            end
            ST_QWRITE: begin
                mem_we  = 1'b1;
                if (r_count == '0) begin
                    n_first = r_item.frame_stamp;
                end
                n_count = r_count + 1'b1;
                n_bytes = sum_bytes[12:0];
                if (n_count == CNT_W'(QUEUE_DEPTH)) begin
                    n_post  = 1'b1;
                    n_more  = 1'b0;
                    n_idx   = '0;
                    n_state = ST_FL_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SPLIT: begin
                if (out_free) begin
                    out_load               = 1'b1;
                    out_d.is_video         = r_vid;
                    out_d.chunk_frame      = r_item.frame_id;
                    out_d.chunk_start      = r_off;
                    out_d.chunk_bytes      = piece;
                    out_d.has_audio_header = !r_vid;
                    out_d.header_offset    = r_vid ? 16'd0 : {2'd0, r_off};
                    out_d.packet_stamp     = r_item.frame_stamp;
                    out_d.marker           = fin;
                    out_d.end_of_packet    = 1'b1;
                    out_d.last             = fin;
                    n_off                  = r_off + {1'b0, piece};
                    if (fin) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Writes happen only in the queue-write state and reads only in the read
    // state, so the two ports never touch the memory in the same cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_q[r_count[QA_W-1:0]] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem_q[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
            r_pay       <= PAY_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_data < PAY_MIN) begin
                    r_pay <= PAY_MIN;
                end else if (i_cfg_data > PAY_MAX) begin
                    r_pay <= PAY_MAX;
                end else begin
                    r_pay <= i_cfg_data;
                end
            end
        end
        r_item  <= n_item;
        r_first <= n_first;
        r_idx   <= n_idx;
        r_off   <= n_off;
        r_vid   <= n_vid;
        r_fits  <= n_fits;
        r_more  <= n_more;
        r_post  <= n_post;
        if (out_load) begin
            r_out_data <= out_d;
        end
    end

    // The fill count never runs past the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // An empty queue holds no bytes.
    a_empty_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_bytes == '0))
        else $error("byte count nonzero with empty queue");

    // The queue memory is never read and written in the same cycle.
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("queue memory read and write collide");

    // After the final chunk of an item the sequencer is idle again, or it
    // queues the frame whose arrival flushed the packet.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && out_d.last) |=> ((r_state == ST_IDLE) || (r_state == ST_QWRITE)))
        else $error("sequencer busy after last chunk");

    // An accepted item closes the input until it has been worked off.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while busy");

endmodule
